[hw/rtl/dpc_pkg.sv]
// Shared types, widths and helpers for the disk pair collision pipeline.
// Depends on nothing; every other file of the block imports it.
package dpc_pkg;

  localparam int WORD_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int RAD_W     = 10;
  localparam int DIFF_W    = WORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int ABC_W     = PROD_W + 2;
  localparam int NBITS_W   = $clog2(ABC_W + 1);
  localparam int NORM_BITS = 62;
  localparam int SHIFT_W   = $clog2(ABC_W - NORM_BITS + 1);
  localparam int ROOT_W    = NORM_BITS + 1;
  localparam int SQ_W      = 2 * NORM_BITS + 2;
  localparam int MUL_LO    = 32;
  localparam int DIV_W     = ABC_W;
  localparam int QUO_W     = WORD_W - 1;
  localparam int REM_W     = DIV_W + FRAC_W;
  localparam int DIV_LAT   = QUO_W + 1;
  localparam int FRONT_LAT = 10;
  localparam int SAT_W     = 2 * WORD_W + 2;

  localparam logic [RAD_W-1:0] RAD_RESET = RAD_W'(5);

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [DIFF_W-1:0] diff_t;

  typedef struct packed {
    word_t first_pos_x;
    word_t first_pos_y;
    word_t first_vel_x;
    word_t first_vel_y;
    word_t second_pos_x;
    word_t second_pos_y;
    word_t second_vel_x;
    word_t second_vel_y;
  } in_t;

  typedef struct packed {
    word_t new_first_pos_x;
    word_t new_first_pos_y;
    word_t new_first_vel_x;
    word_t new_first_vel_y;
    word_t new_second_pos_x;
    word_t new_second_pos_y;
    word_t new_second_vel_x;
    word_t new_second_vel_y;
    logic  no_contact;
  } out_t;

  // Normalized quadratic terms handed from the front end to the root unit.
  typedef struct packed {
    logic signed [SQ_W-1:0]   disc;
    logic signed [ROOT_W:0]   bp;
    logic [NORM_BITS-1:0]     ap;
    logic                     nc;
  } front_t;

  function automatic word_t sat_word(input logic signed [SAT_W-1:0] x);
    priority if (x[SAT_W-1:WORD_W-1] == '0 || x[SAT_W-1:WORD_W-1] == '1) begin
      return x[WORD_W-1:0];
    end else if (x[SAT_W-1]) begin
      return {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(WORD_W-1){1'b1}}};
    end
  endfunction

endpackage

[hw/rtl/dpc_front.sv]
// Front end: relative motion, quadratic terms, normalization and discriminant.
// Depends on dpc_pkg; ten register stages from item to result.
module dpc_front (
  input  logic                      clk,
  input  dpc_pkg::in_t              item,
  input  logic [dpc_pkg::RAD_W-1:0] radius,
  output dpc_pkg::front_t           res
);
  import dpc_pkg::*;

  logic [2*RAD_W-1:0]       rsq;
  logic signed [DIFF_W-1:0] px1, py1, vx1, vy1;
  logic [2*RAD_W+1:0]       rr1, rr2;
  logic signed [PROD_W-1:0] pxx2, pyy2, pxv2, pyv2, vxx2, vyy2;
  logic signed [ABC_W-1:0]  a3, b3, c3, a4, b4, c4, a5, b5, c5;
  logic [ABC_W-1:0]         absb3, absc3, mag4;
  logic                     az4, az5;
  logic [NBITS_W-1:0]       nbits;
  logic [SHIFT_W-1:0]       sh5;
  logic signed [ABC_W-1:0]  as5, bs5, cs5;
  logic signed [ROOT_W:0]   bp6, cp6, bp7, bp8, bp9;
  logic [NORM_BITS-1:0]     ap6, ap7, ap8, ap9;
  logic                     nc6, nc7, nc8, nc9, cn7, cn8, cn9;
  logic [ROOT_W-1:0]        mb7, mc7;
  logic [2*MUL_LO-1:0]      bhh8, bhl8, bll8, ahh8, ahl8, alh8, all8;
  logic [SQ_W-2:0]          bb9, ac9;

  assign rsq   = (2*RAD_W)'(radius) * (2*RAD_W)'(radius);
  assign absb3 = b3[ABC_W-1] ? -b3 : b3;
  assign absc3 = c3[ABC_W-1] ? -c3 : c3;

  always_comb begin
    nbits = '0;
    for (int i = 0; i < ABC_W; i++) begin
      if (mag4[i]) nbits = NBITS_W'(i + 1);
    end
  end

  assign as5 = a5 >>> sh5;
  assign bs5 = b5 >>> sh5;
  assign cs5 = c5 >>> sh5;

  always_ff @(posedge clk) begin
    px1 <= DIFF_W'(item.second_pos_x) - DIFF_W'(item.first_pos_x);
    py1 <= DIFF_W'(item.second_pos_y) - DIFF_W'(item.first_pos_y);
    vx1 <= DIFF_W'(item.second_vel_x) - DIFF_W'(item.first_vel_x);
    vy1 <= DIFF_W'(item.second_vel_y) - DIFF_W'(item.first_vel_y);
    rr1 <= {rsq, 2'b00};

    pxx2 <= px1 * px1;
    pyy2 <= py1 * py1;
    pxv2 <= px1 * vx1;
    pyv2 <= py1 * vy1;
    vxx2 <= vx1 * vx1;
    vyy2 <= vy1 * vy1;
    rr2  <= rr1;

    a3 <= ABC_W'(vxx2) + ABC_W'(vyy2);
    b3 <= ABC_W'(pxv2) + ABC_W'(pyv2);
    c3 <= ABC_W'(pxx2) + ABC_W'(pyy2) - $signed(ABC_W'({rr2, (2*FRAC_W)'(0)}));

    a4   <= a3;
    b4   <= b3;
    c4   <= c3;
    mag4 <= a3 | absb3 | absc3;
    az4  <= (a3 == '0);

    // Shift so that the largest term keeps at most NORM_BITS bits.
    a5  <= a4;
    b5  <= b4;
    c5  <= c4;
    az5 <= az4;
    sh5 <= (nbits > NBITS_W'(NORM_BITS)) ? SHIFT_W'(nbits - NBITS_W'(NORM_BITS)) : '0;

    ap6 <= as5[NORM_BITS-1:0];
    bp6 <= bs5[ROOT_W:0];
    cp6 <= cs5[ROOT_W:0];
    nc6 <= az5 || (as5[NORM_BITS-1:0] == '0);

    mb7 <= bp6[ROOT_W] ? ROOT_W'(-bp6) : bp6[ROOT_W-1:0];
    mc7 <= cp6[ROOT_W] ? ROOT_W'(-cp6) : cp6[ROOT_W-1:0];
    cn7 <= cp6[ROOT_W];
    ap7 <= ap6;
    bp7 <= bp6;
    nc7 <= nc6;

    // Both products are split into partial products of at most 32 by 32 bits.
    bhh8 <= mb7[ROOT_W-1:MUL_LO] * mb7[ROOT_W-1:MUL_LO];
    bhl8 <= mb7[ROOT_W-1:MUL_LO] * mb7[MUL_LO-1:0];
    bll8 <= mb7[MUL_LO-1:0] * mb7[MUL_LO-1:0];
    ahh8 <= ap7[NORM_BITS-1:MUL_LO] * mc7[ROOT_W-1:MUL_LO];
    ahl8 <= ap7[NORM_BITS-1:MUL_LO] * mc7[MUL_LO-1:0];
    alh8 <= ap7[MUL_LO-1:0] * mc7[ROOT_W-1:MUL_LO];
    all8 <= ap7[MUL_LO-1:0] * mc7[MUL_LO-1:0];
    cn8  <= cn7;
    ap8  <= ap7;
    bp8  <= bp7;
    nc8  <= nc7;

    bb9 <= ((SQ_W-1)'(bhh8) << (2*MUL_LO)) + ((SQ_W-1)'(bhl8) << (MUL_LO+1))
           + (SQ_W-1)'(bll8);
    ac9 <= ((SQ_W-1)'(ahh8) << (2*MUL_LO))
           + (((SQ_W-1)'(ahl8) + (SQ_W-1)'(alh8)) << MUL_LO) + (SQ_W-1)'(all8);
    cn9 <= cn8;
    ap9 <= ap8;
    bp9 <= bp8;
    nc9 <= nc8;

    res.disc <= cn9 ? $signed({1'b0, bb9}) + $signed({1'b0, ac9})
                    : $signed({1'b0, bb9}) - $signed({1'b0, ac9});
    res.bp   <= bp9;
    res.ap   <= ap9;
    res.nc   <= nc9;
  end

endmodule

[hw/rtl/dpc_sqrt.sv]
// Pipelined integer square root, one result bit per register stage.
// Depends on dpc_pkg for the radicand and root widths.
module dpc_sqrt (
  input  logic                        clk,
  input  logic [dpc_pkg::SQ_W-2:0]    radicand,
  output logic [dpc_pkg::ROOT_W-1:0]  root
);
  import dpc_pkg::*;

  localparam int RW = SQ_W - 1;

  logic [RW-1:0] rem [1:ROOT_W];
  logic [RW-1:0] acc [1:ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_step
    localparam logic [RW-1:0] ONE_BIT = RW'(1) << (2 * (ROOT_W - 1 - i));
    logic [RW-1:0] cur_rem, cur_acc, trial;

    if (i == 0) begin : g_first
      assign cur_rem = radicand;
      assign cur_acc = '0;
    end else begin : g_rest
      assign cur_rem = rem[i];
      assign cur_acc = acc[i];
    end

    assign trial = cur_acc + ONE_BIT;

    always_ff @(posedge clk) begin
      if (cur_rem >= trial) begin
        rem[i+1] <= cur_rem - trial;
        acc[i+1] <= (cur_acc >> 1) + ONE_BIT;
      end else begin
        rem[i+1] <= cur_rem;
        acc[i+1] <= cur_acc >> 1;
      end
    end
  end

  assign root = acc[ROOT_W][ROOT_W-1:0];

endmodule

[hw/rtl/dpc_div.sv]
// Pipelined restoring divider giving floor(num * 2^FRAC_W / den), clamped to the
// positive word range. One quotient bit per stage. Depends on dpc_pkg.
module dpc_div (
  input  logic                       clk,
  input  logic [dpc_pkg::DIV_W-1:0]  num,
  input  logic [dpc_pkg::DIV_W-1:0]  den,
  output logic [dpc_pkg::QUO_W-1:0]  quo
);
  import dpc_pkg::*;

  logic [REM_W-1:0] rem   [0:QUO_W];
  logic [DIV_W-1:0] den_d [0:QUO_W];
  logic [QUO_W-1:0] qv    [0:QUO_W];
  logic             ovf   [0:QUO_W];

  // The quotient overflows exactly when num reaches den shifted to the word top.
  always_ff @(posedge clk) begin
    rem[0]   <= {num, FRAC_W'(0)};
    den_d[0] <= den;
    qv[0]    <= '0;
    ovf[0]   <= ({(QUO_W-FRAC_W)'(0), num} >= {den, (QUO_W-FRAC_W)'(0)});
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_bit
    localparam int B = QUO_W - 1 - j;
    logic [REM_W-1:0] hi;
    assign hi = rem[j] >> B;

    always_ff @(posedge clk) begin
      den_d[j+1] <= den_d[j];
      ovf[j+1]   <= ovf[j];
      if (hi >= REM_W'(den_d[j])) begin
        rem[j+1] <= rem[j] - (REM_W'(den_d[j]) << B);
        qv[j+1]  <= qv[j] | (QUO_W'(1) << B);
      end else begin
        rem[j+1] <= rem[j];
        qv[j+1]  <= qv[j];
      end
    end
  end

  assign quo = ovf[QUO_W] ? '1 : qv[QUO_W];

endmodule

[hw/rtl/disk_pair_elastic_collision.sv]
// Equal-mass elastic collision of two overlapping disks, fully pipelined.
// Depends on dpc_pkg, dpc_front, dpc_sqrt and dpc_div.
//
// Usage:
//   An item (both disks' positions and velocities, signed Q16.16) is taken on
//   a rising edge with start high and busy low. busy is high only during reset,
//   so one item may enter in every cycle.
//   Each item gives one result on result, marked by done for one cycle, in order.
//   The receiver cannot stall the block; results must be taken as they appear.
//   The pipeline depth is set by the 63-stage square root and the two 32-stage
//   dividers (contact time and impulse), plus the multiply and saturate stages
//   around them. Throughput is one item per cycle.
//   The radius register is written through cfg_valid/cfg_ready/cfg_data; ready
//   is always high. Write it only while no item is in flight.
//   Reset clears the pipeline valid bits and sets the radius to 5. Items with
//   no valid contact come back unchanged with no_contact set.
module disk_pair_elastic_collision (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  dpc_pkg::in_t              item,
  output logic                      done,
  output dpc_pkg::out_t             result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [dpc_pkg::RAD_W-1:0] cfg_data
);
  import dpc_pkg::*;

  localparam int P_FR  = FRONT_LAT;
  localparam int P_SQ  = P_FR + ROOT_W;
  localparam int P_Q   = P_SQ + 1;
  localparam int P_T   = P_Q + DIV_LAT;
  localparam int P_VT  = P_T + 1;
  localparam int P_TP  = P_VT + 1;
  localparam int P_DU  = P_TP + 1;
  localparam int P_UD  = P_DU + 1;
  localparam int P_NM  = P_UD + 1;
  localparam int P_K   = P_NM + DIV_LAT;
  localparam int P_KS  = P_K + 1;
  localparam int P_KD  = P_KS + 1;
  localparam int P_NV  = P_KD + 1;
  localparam int P_NT  = P_NV + 1;
  localparam int P_OUT = P_NT + 1;

  typedef struct packed {
    logic signed [ROOT_W:0] bp;
    logic [NORM_BITS-1:0]   ap;
    logic                   nc;
  } side_t;

  typedef word_t quad_t [2][2];
  typedef logic signed [2*WORD_W-1:0] wprod_t;

  logic [RAD_W-1:0]         radius;
  logic                     accept;
  logic [P_OUT:1]           vld;
  in_t                      ctx    [1:P_NT];
  front_t                   fr;
  side_t                    side_d [P_FR+1:P_SQ];
  logic [ROOT_W-1:0]        root;
  logic signed [ROOT_W+1:0] qsum;
  logic [ROOT_W+1:0]        qmag;
  logic [NORM_BITS-1:0]     ap_q;
  logic                     nc_d   [P_Q:P_NT];
  logic [QUO_W-1:0]         t_comb, k_comb;
  logic [QUO_W-1:0]         t_d    [P_VT:P_NV];
  wprod_t                   vt     [2][2];
  quad_t                    tp_d   [P_TP:P_NT];
  diff_t                    d_d    [P_DU:P_KS][2];
  diff_t                    uu     [2];
  logic signed [PROD_W-1:0] ud     [2];
  logic signed [PROD_W-1:0] dsq    [2];
  logic signed [ABC_W-1:0]  nsum, msum;
  logic [DIV_W-1:0]         nmag, mm;
  logic                     ns_d   [P_NM:P_K];
  logic                     mz_d   [P_NM:P_NT];
  word_t                    ks;
  logic signed [WORD_W+DIFF_W-1:0] kd [2];
  quad_t                    nv, nv_nt;
  wprod_t                   nvt    [2][2];
  quad_t                    np;

  function automatic word_t pos_of(in_t x, logic dk, logic ax);
    word_t r;
    unique case ({dk, ax})
      2'b00:   r = x.first_pos_x;
      2'b01:   r = x.first_pos_y;
      2'b10:   r = x.second_pos_x;
      default: r = x.second_pos_y;
    endcase
    return r;
  endfunction

  function automatic word_t vel_of(in_t x, logic dk, logic ax);
    word_t r;
    unique case ({dk, ax})
      2'b00:   r = x.first_vel_x;
      2'b01:   r = x.first_vel_y;
      2'b10:   r = x.second_vel_x;
      default: r = x.second_vel_y;
    endcase
    return r;
  endfunction

  assign busy      = rst;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign done      = vld[P_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RAD_RESET;
      vld    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) radius <= cfg_data;
      vld <= {vld[P_OUT-1:1], accept};
    end
  end

  // The item itself travels alongside the arithmetic for the later stages.
  always_ff @(posedge clk) begin
    ctx[1] <= item;
    for (int i = 2; i <= P_NT; i++) ctx[i] <= ctx[i-1];
  end

  dpc_front u_front (
    .clk    (clk),
    .item   (item),
    .radius (radius),
    .res    (fr)
  );

  dpc_sqrt u_sqrt (
    .clk      (clk),
    .radicand (fr.disc[SQ_W-2:0]),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    side_d[P_FR+1].bp <= fr.bp;
    side_d[P_FR+1].ap <= fr.ap;
    side_d[P_FR+1].nc <= fr.nc || fr.disc[SQ_W-1];
    for (int i = P_FR + 2; i <= P_SQ; i++) side_d[i] <= side_d[i-1];
  end

  // Positive root of the contact equation, then its magnitude.
  assign qsum = (ROOT_W+2)'(side_d[P_SQ].bp) + $signed({2'b00, root});

  always_ff @(posedge clk) begin
    qmag    <= qsum[ROOT_W+1] ? (ROOT_W+2)'(-qsum) : qsum;
    ap_q    <= side_d[P_SQ].ap;
    nc_d[P_Q] <= side_d[P_SQ].nc;
    for (int i = P_Q + 1; i <= P_NT; i++) nc_d[i] <= nc_d[i-1];
  end

  dpc_div u_div_t (
    .clk (clk),
    .num (DIV_W'(qmag)),
    .den (DIV_W'(ap_q)),
    .quo (t_comb)
  );

  // Rewind both disks by t, then form the relative separation and velocity.
  always_ff @(posedge clk) begin
    t_d[P_VT] <= t_comb;
    for (int i = P_VT + 1; i <= P_NV; i++) t_d[i] <= t_d[i-1];
    for (int dk = 0; dk < 2; dk++) begin
      for (int ax = 0; ax < 2; ax++) begin
        vt[dk][ax] <= vel_of(ctx[P_T], dk[0], ax[0]) * $signed({1'b0, t_comb});
        tp_d[P_TP][dk][ax] <= sat_word(SAT_W'(pos_of(ctx[P_VT], dk[0], ax[0]))
                                       - SAT_W'(vt[dk][ax] >>> FRAC_W));
      end
    end
    for (int i = P_TP + 1; i <= P_NT; i++) tp_d[i] <= tp_d[i-1];
    for (int ax = 0; ax < 2; ax++) begin
      d_d[P_DU][ax] <= DIFF_W'(tp_d[P_TP][0][ax]) - DIFF_W'(tp_d[P_TP][1][ax]);
      uu[ax]        <= DIFF_W'(vel_of(ctx[P_TP], 1'b0, ax[0]))
                       - DIFF_W'(vel_of(ctx[P_TP], 1'b1, ax[0]));
      ud[ax]        <= uu[ax] * d_d[P_DU][ax];
      dsq[ax]       <= d_d[P_DU][ax] * d_d[P_DU][ax];
    end
    for (int i = P_DU + 1; i <= P_KS; i++) d_d[i] <= d_d[i-1];
  end

  assign nsum = ABC_W'(ud[0]) + ABC_W'(ud[1]);
  assign msum = ABC_W'(dsq[0]) + ABC_W'(dsq[1]);

  always_ff @(posedge clk) begin
    nmag       <= nsum[ABC_W-1] ? DIV_W'(-nsum) : DIV_W'(nsum);
    mm         <= DIV_W'(msum);
    ns_d[P_NM] <= nsum[ABC_W-1];
    mz_d[P_NM] <= (msum == '0);
    for (int i = P_NM + 1; i <= P_K; i++) ns_d[i] <= ns_d[i-1];
    for (int i = P_NM + 1; i <= P_NT; i++) mz_d[i] <= mz_d[i-1];
  end

  dpc_div u_div_k (
    .clk (clk),
    .num (nmag),
    .den (mm),
    .quo (k_comb)
  );

  // Exchange the velocity components along the line of centres, move forward.
  always_ff @(posedge clk) begin
    ks <= ns_d[P_K] ? -$signed({1'b0, k_comb}) : $signed({1'b0, k_comb});
    for (int ax = 0; ax < 2; ax++) begin
      kd[ax]    <= ks * d_d[P_KS][ax];
      nv[0][ax] <= sat_word(SAT_W'(vel_of(ctx[P_KD], 1'b0, ax[0]))
                            - SAT_W'(kd[ax] >>> FRAC_W));
      nv[1][ax] <= sat_word(SAT_W'(vel_of(ctx[P_KD], 1'b1, ax[0]))
                            + SAT_W'(kd[ax] >>> FRAC_W));
    end
    for (int dk = 0; dk < 2; dk++) begin
      for (int ax = 0; ax < 2; ax++) begin
        nvt[dk][ax]   <= nv[dk][ax] * $signed({1'b0, t_d[P_NV]});
        nv_nt[dk][ax] <= nv[dk][ax];
      end
    end
  end

  always_comb begin
    for (int dk = 0; dk < 2; dk++) begin
      for (int ax = 0; ax < 2; ax++) begin
        np[dk][ax] = sat_word(SAT_W'(tp_d[P_NT][dk][ax]) + SAT_W'(nvt[dk][ax] >>> FRAC_W));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (nc_d[P_NT] || mz_d[P_NT]) begin
      result.new_first_pos_x  <= ctx[P_NT].first_pos_x;
      result.new_first_pos_y  <= ctx[P_NT].first_pos_y;
      result.new_first_vel_x  <= ctx[P_NT].first_vel_x;
      result.new_first_vel_y  <= ctx[P_NT].first_vel_y;
      result.new_second_pos_x <= ctx[P_NT].second_pos_x;
      result.new_second_pos_y <= ctx[P_NT].second_pos_y;
      result.new_second_vel_x <= ctx[P_NT].second_vel_x;
      result.new_second_vel_y <= ctx[P_NT].second_vel_y;
      result.no_contact       <= 1'b1;
    end else begin
      result.new_first_pos_x  <= np[0][0];
      result.new_first_pos_y  <= np[0][1];
      result.new_first_vel_x  <= nv_nt[0][0];
      result.new_first_vel_y  <= nv_nt[0][1];
      result.new_second_pos_x <= np[1][0];
      result.new_second_pos_y <= np[1][1];
      result.new_second_vel_x <= nv_nt[1][0];
      result.new_second_vel_y <= nv_nt[1][1];
      result.no_contact       <= 1'b0;
    end
  end

endmodule
